>>> hw/rtl/lcmc_pkg.sv
package lcmc_pkg;

   localparam int RANGE_W   = 16;
   localparam int POS_W     = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TRIG_W    = 32;
   localparam int Q_FRAC    = 30;

   localparam int TRIG_TABLE_DEPTH_DEF = 256;
   localparam int SECTOR_MAX_BEAMS     = 512;

   localparam logic [POS_W-1:0]   CENTRE_RST    = 9'd227;
   localparam logic [RANGE_W-1:0] HW_BEFORE_RST = 16'd150;
   localparam logic [RANGE_W-1:0] HW_AFTER_RST  = 16'd330;
   localparam logic [RANGE_W-1:0] INVALID_RST   = 16'd10000;
   localparam logic [RANGE_W-1:0] INIT_MIN_RST  = 16'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTRE_POSITION = 3'd0,
      CSR_HALF_WIDTH_BEFORE = 3'd1,
      CSR_HALF_WIDTH_AFTER = 3'd2,
      CSR_INVALID_ABOVE = 3'd3,
      CSR_INITIAL_MINIMUM = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] offset;
      logic             in_range;
   } rom_req_type;

endpackage

>>> hw/rtl/lcmc_trig_rom.sv
module lcmc_trig_rom #(
   parameter int DEPTH = lcmc_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  lcmc_pkg::rom_req_type              req,
   output logic signed [lcmc_pkg::TRIG_W-1:0] sin_q,
   output logic signed [lcmc_pkg::TRIG_W-1:0] cos_q
);
   import lcmc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam longint Q_ONE    = 64'sd1 << Q_FRAC;
   localparam longint Q_HALF   = 64'sd1 << (Q_FRAC - 1);
   localparam longint STEP_SIN = 64'sd7421854;
   localparam longint STEP_COS = 64'sd1073716173;

   typedef logic signed [TRIG_W-1:0] tab_type [DEPTH];

   function automatic longint round_q(longint p);
      if (p >= 0) begin
         return (p + Q_HALF) >>> Q_FRAC;
      end
      return -((-p + Q_HALF) >>> Q_FRAC);
   endfunction

   function automatic tab_type build_tab(bit want_sin);
      tab_type t;
      longint  c;
      longint  s;
      longint  nc;
      longint  ns;
      c = Q_ONE;
      s = 0;
      for (int i = 0; i < DEPTH; i++) begin
         t[i] = want_sin ? TRIG_W'(s) : TRIG_W'(c);
         nc = round_q(c * STEP_COS - s * STEP_SIN);
         ns = round_q(s * STEP_COS + c * STEP_SIN);
         c = nc;
         s = ns;
      end
      return t;
   endfunction

   localparam tab_type SIN_TAB = build_tab(1'b1);
   localparam tab_type COS_TAB = build_tab(1'b0);

   logic [AW-1:0] addr;

   assign addr = req.in_range ? AW'(req.offset) : '0;

   always_ff @(posedge clock) begin
      if (req.en) begin
         sin_q <= SIN_TAB[addr];
         cos_q <= COS_TAB[addr];
      end
   end

endmodule

>>> hw/rtl/lidar_corridor_min_clearance_core.sv
// A last beam passes registers s1, s2, s3 and rsp before its result shows on rsp.
// Throughput: one beam per cycle; the pipeline holds only while a sector result
//    waits at rsp with a further last beam ready behind it.
// Reset: synchronous, active high; clears valids, loads register defaults and
//    arms the first-beam flag. No clearing pass.
module lidar_corridor_min_clearance_core #(
   parameter int TRIG_TABLE_DEPTH = lcmc_pkg::TRIG_TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // range_mm, beam_position
   input  logic                                req_tlast,  // last_beam
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lcmc_pkg::RANGE_W-1:0]        rsp_tdata,  // min_forward_mm
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcmc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lcmc_pkg::*;

   localparam int PROD_W = RANGE_W + 1 + TRIG_W;

   logic [POS_W-1:0]   centre_ff;
   logic [RANGE_W-1:0] hw_before_ff, hw_after_ff, invalid_ff, init_min_ff;

   logic               s1_valid_ff, s1_last_ff;
   logic [RANGE_W-1:0] s1_range_ff;
   logic [POS_W-1:0]   s1_pos_ff;

   logic               first_pending_ff;
   logic [RANGE_W-1:0] kept_ff, kept_in;
   logic [POS_W-1:0]   offset_in;
   logic [RANGE_W-1:0] limit_in;
   logic               in_range_in;

   logic               s2_valid_ff, s2_last_ff, s2_first_ff, s2_in_range_ff;
   logic [RANGE_W-1:0] s2_kept_ff, s2_limit_ff;
   logic signed [TRIG_W-1:0] sin_q, cos_q;
   logic signed [PROD_W-1:0] lat_in, fwd_in;

   logic               s3_valid_ff, s3_last_ff, s3_first_ff, s3_in_range_ff;
   logic [RANGE_W-1:0] s3_limit_ff;
   logic signed [PROD_W-1:0] s3_lat_ff, s3_fwd_ff;

   logic [RANGE_W-1:0] run_min_ff, base_min, fwd_mm, new_min;
   logic               include_beam;
   logic [PROD_W-Q_FRAC-1:0] fwd_q;

   logic               rsp_valid_ff;
   logic [RANGE_W-1:0] rsp_data_ff;

   logic               adv;
   rom_req_type        rom_req;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff    <= CENTRE_RST;
         hw_before_ff <= HW_BEFORE_RST;
         hw_after_ff  <= HW_AFTER_RST;
         invalid_ff   <= INVALID_RST;
         init_min_ff  <= INIT_MIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTRE_POSITION:   centre_ff    <= csr_data[POS_W-1:0];
            CSR_HALF_WIDTH_BEFORE: hw_before_ff <= csr_data;
            CSR_HALF_WIDTH_AFTER:  hw_after_ff  <= csr_data;
            CSR_INVALID_ABOVE:     invalid_ff   <= csr_data;
            CSR_INITIAL_MINIMUM:   init_min_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // hold everything only when a sector result cannot leave
   assign adv        = !(s3_valid_ff && s3_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_range_ff <= req_tdata[RANGE_W-1:0];
         s1_pos_ff   <= req_tdata[RANGE_W +: POS_W];
         s1_last_ff  <= req_tlast;
      end
   end

   always_comb begin
      kept_in = kept_ff;
      if (first_pending_ff || s1_range_ff <= invalid_ff) begin
         kept_in = s1_range_ff;
      end
      if (s1_pos_ff < centre_ff) begin
         offset_in = centre_ff - s1_pos_ff;
         limit_in  = hw_before_ff;
      end else begin
         offset_in = s1_pos_ff - centre_ff;
         limit_in  = hw_after_ff;
      end
      in_range_in = (32'(offset_in) < 32'(TRIG_TABLE_DEPTH)) &&
                    (32'(s1_pos_ff) < 32'(SECTOR_MAX_BEAMS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
      end else if (adv && s1_valid_ff) begin
         first_pending_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
      end else if (adv && s1_valid_ff) begin
         kept_ff <= kept_in;
      end
   end

   assign rom_req.en       = adv;
   assign rom_req.offset   = offset_in;
   assign rom_req.in_range = in_range_in;

   lcmc_trig_rom #(
      .DEPTH (TRIG_TABLE_DEPTH)
   ) u_trig_rom (
      .clock (clock),
      .req   (rom_req),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_last_ff     <= s1_last_ff;
         s2_first_ff    <= first_pending_ff;
         s2_in_range_ff <= in_range_in;
         s2_kept_ff     <= kept_in;
         s2_limit_ff    <= limit_in;
      end
   end

   assign lat_in = $signed({1'b0, s2_kept_ff}) * sin_q;
   assign fwd_in = $signed({1'b0, s2_kept_ff}) * cos_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_last_ff     <= s2_last_ff;
         s3_first_ff    <= s2_first_ff;
         s3_in_range_ff <= s2_in_range_ff;
         s3_limit_ff    <= s2_limit_ff;
         s3_lat_ff      <= lat_in;
         s3_fwd_ff      <= fwd_in;
      end
   end

   always_comb begin
      base_min     = s3_first_ff ? init_min_ff : run_min_ff;
      include_beam = s3_in_range_ff &&
                     (s3_lat_ff < $signed({{(PROD_W-RANGE_W-Q_FRAC){1'b0}}, s3_limit_ff,
                                            {Q_FRAC{1'b0}}}));
      fwd_q = s3_fwd_ff[PROD_W-1:Q_FRAC];
      priority if (s3_fwd_ff[PROD_W-1] || s3_fwd_ff == '0) begin
         fwd_mm = '0;
      end else if (fwd_q[PROD_W-Q_FRAC-1:RANGE_W] != '0) begin
         fwd_mm = '1;
      end else begin
         fwd_mm = fwd_q[RANGE_W-1:0];
      end
      new_min = (include_beam && fwd_mm < base_min) ? fwd_mm : base_min;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= INIT_MIN_RST;
      end else if (adv && s3_valid_ff) begin
         run_min_ff <= s3_last_ff ? init_min_ff : new_min;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && s3_valid_ff && s3_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_valid_ff && s3_last_ff) begin
         rsp_data_ff <= new_min;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted item did not enter the pipeline");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      (adv && s3_valid_ff && s3_last_ff) |=> rsp_valid_ff)
      else $error("last beam left without a result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff && s3_last_ff))
      else $error("result raised without a last beam");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (!adv && s3_valid_ff) |=> (s3_valid_ff && $stable(s3_fwd_ff)))
      else $error("pipeline moved during stall");
`endif

endmodule
